// ===== design/asd_pkg.sv =====
// Shared types, constants and helper functions of the annulus sector distance block.
// No dependencies; every other design file refers to it by scoped names.
package asd_pkg;

	// Default parameter values.
	localparam int CORDIC_STEPS = 16;
	localparam int FRACTION_BITS = 16;

	// Field widths fixed by the interface.
	localparam int LEN_W = 31;
	localparam int ANG_W = 19;
	localparam int DIST_W = 32;

	// Datapath widths of the rotation chain (Q30 values).
	localparam int XY_W = 34;
	localparam int Z_W = 33;

	// Q30 constants: pi, the CORDIC gain compensation and half of pi (truncated).
	localparam logic signed [63:0] PI_Q30 = 64'sd3373259426;
	localparam logic signed [63:0] K_Q30 = 64'sd652032874;
	localparam logic signed [63:0] HALF_PI_Q30 = 64'sd1686629713;

	// Register indexes of the configuration port.
	typedef enum logic [1:0] {
		REG_R_MIN = 2'd0,
		REG_R_MAX = 2'd1,
		REG_AVERAGE_PHI = 2'd2,
		REG_HALF_PHI_SECTOR = 2'd3
	} reg_idx_t;

	// Side data that travels alongside the rotation chain.
	typedef struct packed {
		logic [LEN_W-1:0] rlo;
		logic [LEN_W-1:0] rhi;
		logic [LEN_W-1:0] r;
		logic zero;
		logic full;
		logic dpos;
		logic neg;
	} side_t;

	// Result bookkeeping that travels alongside the square root chain.
	typedef struct packed {
		logic zero;
		logic use_sqrt;
		logic sat;
		logic [LEN_W-1:0] rlo;
		logic signed [35:0] res;
	} fin_t;

	// Arctangent of 2^-i in Q30 radians.
	function automatic logic [29:0] atan_q30(input int i);
		logic [29:0] v;
		case (i)
			0: v = 30'd843314857;
			1: v = 30'd497837829;
			2: v = 30'd263043837;
			3: v = 30'd133525159;
			4: v = 30'd67021687;
			5: v = 30'd33543516;
			6: v = 30'd16775851;
			7: v = 30'd8388437;
			8: v = 30'd4194283;
			9: v = 30'd2097149;
			default: v = 30'(64'd1 << (30 - i));
		endcase
		return v;
	endfunction

endpackage

// ===== design/asd_ifs.sv =====
// Valid/ready stream interfaces for the point input and the distance output.
// Depends on asd_pkg for the field widths.
interface asd_point_if;
	logic valid;
	logic ready;
	logic [asd_pkg::LEN_W-1:0] radius;
	logic signed [asd_pkg::ANG_W-1:0] phi;
	modport source(output valid, radius, phi, input ready);
	modport sink(input valid, radius, phi, output ready);
endinterface

interface asd_dist_if;
	logic valid;
	logic ready;
	logic signed [asd_pkg::DIST_W-1:0] distance;
	modport source(output valid, distance, input ready);
	modport sink(input valid, distance, output ready);
endinterface

// ===== design/asd_cordic_cell.sv =====
// One rotation step of the sine/cosine chain, registered.
// Depends on asd_pkg for widths, the side record and the arctangent table.
module asd_cordic_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic signed [asd_pkg::XY_W-1:0] x_i,
	input logic signed [asd_pkg::XY_W-1:0] y_i,
	input logic signed [asd_pkg::Z_W-1:0] z_i,
	input asd_pkg::side_t side_i,
	output logic signed [asd_pkg::XY_W-1:0] x_o,
	output logic signed [asd_pkg::XY_W-1:0] y_o,
	output logic signed [asd_pkg::Z_W-1:0] z_o,
	output asd_pkg::side_t side_o
);
	localparam logic signed [asd_pkg::Z_W-1:0] ATAN =
		$signed({3'b000, asd_pkg::atan_q30(STEP)});

	logic signed [asd_pkg::XY_W-1:0] xs, ys;

	assign xs = x_i >>> STEP;
	assign ys = y_i >>> STEP;

	// Rotate toward zero residual angle.
	always_ff @(posedge clk) begin
		if (en) begin
			if (z_i >= 0) begin
				x_o <= x_i - ys;
				y_o <= y_i + xs;
				z_o <= z_i - ATAN;
			end else begin
				x_o <= x_i + ys;
				y_o <= y_i - xs;
				z_o <= z_i + ATAN;
			end
			side_o <= side_i;
		end
	end
endmodule

// ===== design/asd_sqrt_cell.sv =====
// One result-bit step of the integer square root chain, registered.
// Depends on asd_pkg for the result record.
module asd_sqrt_cell #(
	parameter int STEP = 0
) (
	input logic clk,
	input logic en,
	input logic [63:0] n_i,
	input logic [63:0] root_i,
	input asd_pkg::fin_t fin_i,
	output logic [63:0] n_o,
	output logic [63:0] root_o,
	output asd_pkg::fin_t fin_o
);
	localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

	logic [63:0] trial;

	assign trial = root_i + BIT;

	// Subtract the trial value when it fits and set this result bit.
	always_ff @(posedge clk) begin
		if (en) begin
			if (n_i >= trial) begin
				n_o <= n_i - trial;
				root_o <= (root_i >> 1) + BIT;
			end else begin
				n_o <= n_i;
				root_o <= root_i >> 1;
			end
			fin_o <= fin_i;
		end
	end
endmodule

// ===== design/annulus_sector_distance.sv =====
// Signed distance from a polar point to a configured annular sector.
// Depends on asd_pkg, asd_ifs, asd_cordic_cell and asd_sqrt_cell.
//
// The block takes one point per clock cycle unless the output is stalled,
// and returns its distance through the rotation chain
// (one cell per CORDIC step) and the 32-cell square root chain. A stalled
// output holds the whole pipeline. The user must write the sector registers over
// the APB port only while no transaction is in flight; the block does not enforce it.
module annulus_sector_distance #(
	parameter int CORDIC_STEPS = asd_pkg::CORDIC_STEPS,
	parameter int FRACTION_BITS = asd_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	asd_point_if.sink point,
	asd_dist_if.source result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int SH = 30 - FRACTION_BITS;
	localparam longint PI_FX = (64'sd3373259426 + (64'sd1 <<< (29 - FRACTION_BITS))) >>> SH;
	localparam int AQW = 22 + SH;
	localparam int NST = CORDIC_STEPS + 39;
	localparam int LW = asd_pkg::LEN_W;
	localparam int XW = asd_pkg::XY_W;
	localparam int ZW = asd_pkg::Z_W;

	// Configuration registers.
	logic [LW-1:0] r_min_q, r_max_q;
	logic signed [asd_pkg::ANG_W-1:0] average_phi_q;
	logic [asd_pkg::ANG_W-1:0] half_phi_sector_q;
	asd_pkg::reg_idx_t widx;

	assign widx = asd_pkg::reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_min_q <= '0;
			r_max_q <= '0;
			average_phi_q <= '0;
			half_phi_sector_q <= asd_pkg::ANG_W'(PI_FX);
		end else if (psel && penable && pwrite) begin
			case (widx)
				asd_pkg::REG_R_MIN: r_min_q <= pwdata[LW-1:0];
				asd_pkg::REG_R_MAX: r_max_q <= pwdata[LW-1:0];
				asd_pkg::REG_AVERAGE_PHI: average_phi_q <= pwdata[asd_pkg::ANG_W-1:0];
				asd_pkg::REG_HALF_PHI_SECTOR: half_phi_sector_q <= pwdata[asd_pkg::ANG_W-1:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (widx)
			asd_pkg::REG_R_MIN: prdata = {1'b0, r_min_q};
			asd_pkg::REG_R_MAX: prdata = {1'b0, r_max_q};
			asd_pkg::REG_AVERAGE_PHI: prdata = 32'(average_phi_q);
			asd_pkg::REG_HALF_PHI_SECTOR: prdata = {13'b0, half_phi_sector_q};
			default: prdata = '0;
		endcase
	end

	// Pipeline flow: everything advances unless the output is stalled.
	logic en;
	logic [NST-1:0] vld_q;

	assign en = !result.valid || result.ready;
	assign point.ready = en;
	assign result.valid = vld_q[NST-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NST-2:0], point.valid};
		end
	end

	// Angular excess over the half opening, radius ordering and special cases.
	logic signed [19:0] diff;
	logic [19:0] absd, wrapd;
	logic signed [20:0] dsec;
	logic full;

	assign diff = 20'(point.phi) - 20'(average_phi_q);
	assign absd = diff[19] ? 20'(-diff) : 20'(diff);
	assign wrapd = (32'(absd) > 32'(PI_FX)) ? 20'(2 * PI_FX) - absd : absd;
	assign dsec = $signed({1'b0, wrapd}) - $signed({2'b00, half_phi_sector_q});
	assign full = {13'b0, half_phi_sector_q} >= 32'(PI_FX);

	logic signed [20:0] dsec_s1;
	asd_pkg::side_t side_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			dsec_s1 <= dsec;
			side_s1 <= '{rlo: (r_min_q < r_max_q) ? r_min_q : r_max_q,
				rhi: (r_min_q < r_max_q) ? r_max_q : r_min_q,
				r: point.radius,
				zero: point.radius == '0,
				full: full,
				dpos: 1'b0,
				neg: 1'b0};
		end
	end

	// Scale to Q30, wrap into minus pi to pi and fold into the right half plane.
	logic signed [AQW-1:0] a_raw, a_wrap, a_fold;
	logic a_neg;

	assign a_raw = AQW'(dsec_s1) <<< SH;

	always_comb begin
		if (a_raw > AQW'(asd_pkg::PI_Q30)) begin
			a_wrap = a_raw - AQW'(2 * asd_pkg::PI_Q30);
		end else if (a_raw < -AQW'(asd_pkg::PI_Q30)) begin
			a_wrap = a_raw + AQW'(2 * asd_pkg::PI_Q30);
		end else begin
			a_wrap = a_raw;
		end
		if (a_wrap > AQW'(asd_pkg::HALF_PI_Q30)) begin
			a_fold = a_wrap - AQW'(asd_pkg::PI_Q30);
			a_neg = 1'b1;
		end else if (a_wrap < -AQW'(asd_pkg::HALF_PI_Q30)) begin
			a_fold = a_wrap + AQW'(asd_pkg::PI_Q30);
			a_neg = 1'b1;
		end else begin
			a_fold = a_wrap;
			a_neg = 1'b0;
		end
	end

	logic signed [XW-1:0] cx [CORDIC_STEPS+1];
	logic signed [XW-1:0] cy [CORDIC_STEPS+1];
	logic signed [ZW-1:0] cz [CORDIC_STEPS+1];
	asd_pkg::side_t cside [CORDIC_STEPS+1];

	logic signed [XW-1:0] x_s2, y_s2;
	logic signed [ZW-1:0] z_s2;
	asd_pkg::side_t side_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			x_s2 <= XW'(asd_pkg::K_Q30);
			y_s2 <= '0;
			z_s2 <= ZW'(a_fold);
			side_s2 <= '{rlo: side_s1.rlo, rhi: side_s1.rhi, r: side_s1.r,
				zero: side_s1.zero, full: side_s1.full,
				dpos: dsec_s1 > 0, neg: a_neg};
		end
	end

	assign cx[0] = x_s2;
	assign cy[0] = y_s2;
	assign cz[0] = z_s2;
	assign cside[0] = side_s2;

	// Rotation chain.
	for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
		asd_cordic_cell #(.STEP(g)) u_cell (
			.clk(clk), .en(en),
			.x_i(cx[g]), .y_i(cy[g]), .z_i(cz[g]), .side_i(cside[g]),
			.x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]), .side_o(cside[g+1])
		);
	end

	// Project the radius with sine and cosine, rounding half up.
	asd_pkg::side_t sd;
	logic signed [XW-1:0] sn, cs;
	logic signed [65:0] psin, pcos;

	assign sd = cside[CORDIC_STEPS];
	assign sn = sd.neg ? -cy[CORDIC_STEPS] : cy[CORDIC_STEPS];
	assign cs = sd.neg ? -cx[CORDIC_STEPS] : cx[CORDIC_STEPS];
	assign psin = ($signed({1'b0, sd.r}) * sn + 66'sd536870912) >>> 30;
	assign pcos = ($signed({1'b0, sd.r}) * cs + 66'sd536870912) >>> 30;

	logic signed [35:0] sf_s3, rr_s3;
	asd_pkg::side_t side_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= sd;
			if (sd.full) begin
				sf_s3 <= '0;
				rr_s3 <= 36'(sd.r);
			end else begin
				sf_s3 <= 36'(psin);
				rr_s3 <= sd.dpos ? 36'(pcos) : 36'(sd.r);
			end
		end
	end

	// Combine radial and angular excesses; corners go to the square root.
	logic signed [35:0] sr0, sr1, hyp_a, hmax, res_c;
	logic [35:0] ha, hb;
	logic use_sqrt;

	assign sr0 = $signed({5'b0, side_s3.rlo}) - rr_s3;
	assign sr1 = rr_s3 - $signed({5'b0, side_s3.rhi});
	assign hmax = (sr0 > sr1) ? sr0 : sr1;
	assign hyp_a = (sr0 > 0) ? sr0 : sr1;
	assign ha = hyp_a[35] ? 36'(-hyp_a) : 36'(hyp_a);
	assign hb = sf_s3[35] ? 36'(-sf_s3) : 36'(sf_s3);

	always_comb begin
		use_sqrt = 1'b0;
		if (side_s3.full || sf_s3 <= 0) begin
			if (sr0 > 0) begin
				res_c = sr0;
			end else if (sr1 > 0) begin
				res_c = sr1;
			end else if (!side_s3.full && sf_s3 > hmax) begin
				res_c = sf_s3;
			end else begin
				res_c = hmax;
			end
		end else if (sr0 > 0 || sr1 > 0) begin
			res_c = '0;
			use_sqrt = 1'b1;
		end else begin
			res_c = sf_s3;
		end
	end

	asd_pkg::fin_t fin_s4, fin_s5, fin_s6;
	logic [LW-1:0] ha_s4, hb_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			fin_s4 <= '{zero: side_s3.zero, use_sqrt: use_sqrt,
				sat: (ha >= 36'd2147483648) || (hb >= 36'd2147483648),
				rlo: side_s3.rlo, res: res_c};
			ha_s4 <= ha[LW-1:0];
			hb_s4 <= hb[LW-1:0];
		end
	end

	// Squares, then their sum.
	logic [61:0] sqa_s5, sqb_s5;
	logic [63:0] n_s6;

	always_ff @(posedge clk) begin
		if (en) begin
			sqa_s5 <= ha_s4 * ha_s4;
			sqb_s5 <= hb_s4 * hb_s4;
			fin_s5 <= fin_s4;
			n_s6 <= 64'(sqa_s5) + 64'(sqb_s5);
			fin_s6 <= fin_s5;
		end
	end

	// Square root chain.
	logic [63:0] qn [33];
	logic [63:0] qr [33];
	asd_pkg::fin_t qf [33];

	assign qn[0] = n_s6;
	assign qr[0] = '0;
	assign qf[0] = fin_s6;

	for (genvar k = 0; k < 32; k++) begin : g_sqrt
		asd_sqrt_cell #(.STEP(k)) u_cell (
			.clk(clk), .en(en),
			.n_i(qn[k]), .root_i(qr[k]), .fin_i(qf[k]),
			.n_o(qn[k+1]), .root_o(qr[k+1]), .fin_o(qf[k+1])
		);
	end

	// Select and saturate the final distance.
	asd_pkg::fin_t ff;
	logic signed [35:0] pick;

	assign ff = qf[32];

	always_comb begin
		if (ff.zero) begin
			pick = $signed({5'b0, ff.rlo});
		end else if (ff.use_sqrt) begin
			pick = ff.sat ? 36'sd2147483647 : $signed({3'b0, qr[32][32:0]});
		end else begin
			pick = ff.res;
		end
	end

	logic signed [asd_pkg::DIST_W-1:0] dist_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (pick > 36'sd2147483647) begin
				dist_q <= 32'sh7FFFFFFF;
			end else if (pick < -36'sd2147483648) begin
				dist_q <= 32'sh80000000;
			end else begin
				dist_q <= pick[31:0];
			end
		end
	end

	assign result.distance = dist_q;

	// A stalled pipeline keeps its occupancy.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("pipeline occupancy changed during a stall");

	// The folded angle entering the rotation chain lies within a quarter turn.
	a_fold_range: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[0]) |=> (cz[0] <= ZW'(asd_pkg::HALF_PI_Q30)
			&& cz[0] >= -ZW'(asd_pkg::HALF_PI_Q30)))
		else $error("rotation input angle outside a quarter turn");

	// A full disc has no angular part.
	a_full_noang: assert property (@(posedge clk) disable iff (!arst_n)
		(en && vld_q[CORDIC_STEPS+1] && sd.full) |=> (sf_s3 == 0))
		else $error("angular part present for a full disc");
endmodule

// ===== bench/annulus_sector_distance_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of annulus_sector_distance: directed table, then random sectors.
// Depends on asd_pkg, the stream interfaces in asd_ifs and the block itself.
module annulus_sector_distance_tb;

	localparam int PIPE_CYCLES = asd_pkg::CORDIC_STEPS + 39;
	localparam longint ANGLE_PI = (asd_pkg::PI_Q30 + (64'sd1 <<< (29 - asd_pkg::FRACTION_BITS)))
		>>> (30 - asd_pkg::FRACTION_BITS);
	localparam longint ANG_MAX = 205887;
	localparam longint LEN_MAX = 64'h7FFF_FFFF;

	typedef enum bit {ROW_REG, ROW_POINT} row_kind_t;
	typedef struct {
		row_kind_t kind;
		asd_pkg::reg_idx_t idx;
		longint a;
		longint b;
		bit known;
		longint want;
	} row_t;
	typedef struct {
		logic signed [asd_pkg::DIST_W-1:0] distance;
	} dist_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [3:0] paddr;
	logic [31:0] pwdata, prdata;

	asd_point_if pt();
	asd_dist_if rs();

	annulus_sector_distance DUT (
		.clk(clk), .arst_n(arst_n), .point(pt), .result(rs),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Sector settings as the block should hold them.
	longint sec_r_min, sec_r_max, sec_avg_phi, sec_half;
	dist_t pending_dist[$];
	int errors;
	bit quiet;
	int ready_hold;

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic longint arctan_step(input int i);
		longint tab[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
			33543516, 16775851, 8388437, 4194283, 2097149};
		if (i < 10)
			return tab[i];
		return 64'sd1 <<< (30 - i);
	endfunction

	// Fixed-length rotation giving sine and cosine in Q30 of a Q30 angle.
	function automatic void rotate(input longint ang, output longint s, output longint c);
		longint x, y, z, xs, ys;
		bit neg;
		x = asd_pkg::K_Q30;
		y = 0;
		neg = 1'b0;
		while (ang > asd_pkg::PI_Q30) ang -= 2 * asd_pkg::PI_Q30;
		while (ang < -asd_pkg::PI_Q30) ang += 2 * asd_pkg::PI_Q30;
		if (ang > asd_pkg::HALF_PI_Q30) begin
			ang -= asd_pkg::PI_Q30;
			neg = 1'b1;
		end else if (ang < -asd_pkg::HALF_PI_Q30) begin
			ang += asd_pkg::PI_Q30;
			neg = 1'b1;
		end
		z = ang;
		for (int i = 0; i < asd_pkg::CORDIC_STEPS && i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys; y += xs; z -= arctan_step(i);
			end else begin
				x += ys; y -= xs; z += arctan_step(i);
			end
		end
		s = neg ? -y : y;
		c = neg ? -x : x;
	endfunction

	function automatic longint scale_q30(input longint a, input longint b);
		return (a * b + (64'sd1 <<< 29)) >>> 30;
	endfunction

	// Corner length: truncated square root of the sum of squares, saturating.
	function automatic longint corner_length(input longint a, input longint b);
		longint unsigned ua, ub, n, root, bitv;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		if (ua >= 64'd1 << 31 || ub >= 64'd1 << 31)
			return 2147483647;
		n = ua * ua + ub * ub;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= root + bitv) begin
				n -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return longint'(root);
	endfunction

	function automatic longint clamp32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// Signed distance of a polar point to the current sector.
	function automatic longint sector_distance(input longint r, input longint phi);
		longint rlo, rhi, sf, d, s, c, sr0, sr1, res;
		bit full;
		rlo = sec_r_min < sec_r_max ? sec_r_min : sec_r_max;
		rhi = sec_r_min < sec_r_max ? sec_r_max : sec_r_min;
		sf = 0;
		full = 1'b0;
		if (r == 0)
			return clamp32(rlo);
		if (sec_half < ANGLE_PI) begin
			d = phi - sec_avg_phi;
			if (d < 0) d = -d;
			if (d > ANGLE_PI) d = 2 * ANGLE_PI - d;
			d -= sec_half;
			rotate(d <<< (30 - asd_pkg::FRACTION_BITS), s, c);
			sf = scale_q30(r, s);
			if (d > 0) r = scale_q30(r, c);
		end else begin
			full = 1'b1;
		end
		sr0 = rlo - r;
		sr1 = r - rhi;
		if (full || sf <= 0) begin
			if (sr0 > 0) res = sr0;
			else if (sr1 > 0) res = sr1;
			else begin
				res = sr0 > sr1 ? sr0 : sr1;
				if (!full && sf > res) res = sf;
			end
		end else begin
			if (sr0 > 0) res = corner_length(sr0, sf);
			else if (sr1 > 0) res = corner_length(sr1, sf);
			else res = sf;
		end
		return clamp32(res);
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("ERROR %0t: %s: got %0d, expected %0d", $realtime, what, got, want);
		errors++;
	endtask

	// Waits until every expected distance is back and the pipeline has drained.
	task automatic drain_pipeline();
		while (pending_dist.size() != 0) @(posedge clk);
		repeat (PIPE_CYCLES + 4) @(posedge clk);
	endtask

	// APB write: setup cycle, then access cycle.
	task automatic write_reg(input asd_pkg::reg_idx_t idx, input longint value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 4'(idx) << 2;
		pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			asd_pkg::REG_R_MIN: sec_r_min = value & LEN_MAX;
			asd_pkg::REG_R_MAX: sec_r_max = value & LEN_MAX;
			asd_pkg::REG_AVERAGE_PHI: begin
				sec_avg_phi = value & 64'h7FFFF;
				if (sec_avg_phi >= 64'h40000) sec_avg_phi -= 64'h80000;
			end
			asd_pkg::REG_HALF_PHI_SECTOR: sec_half = value & 64'h7FFFF;
			default: ;
		endcase
	endtask

	// Sends one point; the expected distance is queued once the transaction is taken.
	task automatic send_point(input longint r, input longint phi, input bit known,
			input longint want);
		dist_t e;
		if (!quiet && $urandom_range(0, 9) == 0) begin
			pt.valid <= 1'b0;
			repeat ($urandom_range(1, 16)) @(posedge clk);
		end
		pt.valid <= 1'b1;
		pt.radius <= r[asd_pkg::LEN_W-1:0];
		pt.phi <= phi[asd_pkg::ANG_W-1:0];
		@(posedge clk);
		while (!pt.ready) @(posedge clk);
		e.distance = known ? 32'(want) : 32'(sector_distance(r, phi));
		pending_dist.push_back(e);
	endtask

	task automatic write_sector(input longint rmin, input longint rmax, input longint avg,
			input longint half);
		pt.valid <= 1'b0;
		drain_pipeline();
		write_reg(asd_pkg::REG_R_MIN, rmin);
		write_reg(asd_pkg::REG_R_MAX, rmax);
		write_reg(asd_pkg::REG_AVERAGE_PHI, avg);
		write_reg(asd_pkg::REG_HALF_PHI_SECTOR, half);
	endtask

	function automatic longint random_length();
		case ($urandom_range(0, 3))
			0: return $urandom_range(0, 32'h0010_0000);
			1: return $urandom_range(0, 32'h0100_0000);
			default: return $urandom & LEN_MAX;
		endcase
	endfunction

	// Random point, mostly near the sector bounds.
	task automatic send_random_point();
		longint r, phi, base;
		int sel;
		sel = $urandom_range(0, 19);
		if (sel == 0) r = 0;
		else if (sel == 1) r = LEN_MAX;
		else if (sel < 5) r = $urandom & LEN_MAX;
		else begin
			base = $urandom_range(0, 1) ? sec_r_min : sec_r_max;
			r = base + $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
			if (r < 0) r = -r;
			if (r > LEN_MAX) r = LEN_MAX;
		end
		if ($urandom_range(0, 4) == 0) begin
			phi = longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
		end else begin
			phi = sec_avg_phi + ($urandom_range(0, 1) ? sec_half : -sec_half)
				+ longint'($urandom_range(0, 8000)) - 4000;
			if (phi > ANG_MAX) phi -= 2 * ANGLE_PI;
			if (phi < -ANG_MAX) phi += 2 * ANGLE_PI;
			if (phi > ANG_MAX) phi = ANG_MAX;
			if (phi < -ANG_MAX) phi = -ANG_MAX;
		end
		send_point(r, phi, 1'b0, 0);
	endtask

	// Result side: random stall bursts, and each transaction checked in order.
	always @(posedge clk) begin
		dist_t e;
		if (arst_n) begin
			if (rs.valid && rs.ready) begin
				if (pending_dist.size() == 0) begin
					report_mismatch("distance without a pending point", rs.distance, 0);
				end else begin
					e = pending_dist.pop_front();
					if (rs.distance !== e.distance)
						report_mismatch("distance", rs.distance, e.distance);
				end
			end
			if (ready_hold > 0) begin
				ready_hold--;
				rs.ready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 11) == 0) begin
				ready_hold = $urandom_range(1, 16) - 1;
				rs.ready <= 1'b0;
			end else begin
				rs.ready <= 1'b1;
			end
		end
	end

	// Directed table: reset settings, then swapped radii and angle wrap cases.
	row_t directed[] = '{
		'{ROW_POINT, asd_pkg::REG_R_MIN, 0, 0, 1, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, LEN_MAX, 0, 1, LEN_MAX},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 1, ANG_MAX, 1, 1},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 1, -ANG_MAX, 1, 1},
		'{ROW_REG, asd_pkg::REG_R_MIN, 20 << 16, 0, 0, 0},
		'{ROW_REG, asd_pkg::REG_R_MAX, 10 << 16, 0, 0, 0},
		'{ROW_REG, asd_pkg::REG_HALF_PHI_SECTOR, 51472, 0, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 0, 12345, 1, 10 << 16},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 15 << 16, 0, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 30 << 16, 100000, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 5 << 16, -150000, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, LEN_MAX, ANG_MAX, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 1, -ANG_MAX, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 25 << 16, 51000, 0, 0},
		'{ROW_REG, asd_pkg::REG_AVERAGE_PHI, -ANG_MAX, 0, 0, 0},
		'{ROW_REG, asd_pkg::REG_HALF_PHI_SECTOR, 0, 0, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 15 << 16, ANG_MAX, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 15 << 16, -ANG_MAX, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 40 << 16, 0, 0, 0},
		'{ROW_REG, asd_pkg::REG_R_MIN, LEN_MAX, 0, 0, 0},
		'{ROW_REG, asd_pkg::REG_HALF_PHI_SECTOR, 411775, 0, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, LEN_MAX, 0, 0, 0},
		'{ROW_POINT, asd_pkg::REG_R_MIN, 1, 0, 0, 0}
	};

	initial begin
		errors = 0;
		quiet = 1'b0;
		ready_hold = 0;
		sec_r_min = 0;
		sec_r_max = 0;
		sec_avg_phi = 0;
		sec_half = ANGLE_PI;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		pt.valid = 1'b0;
		pt.radius = '0;
		pt.phi = '0;
		rs.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_REG) begin
				pt.valid <= 1'b0;
				drain_pipeline();
				write_reg(directed[i].idx, directed[i].a);
			end else begin
				send_point(directed[i].a, directed[i].b, directed[i].known, directed[i].want);
			end
		end

		// Random sectors, the extremes among them; the last one runs without stalls.
		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: write_sector(LEN_MAX, 0, ANG_MAX, 411775);
				1: write_sector(0, LEN_MAX, -ANG_MAX, 0);
				2: write_sector(LEN_MAX, LEN_MAX, 0, ANGLE_PI - 1);
				default: write_sector(random_length(), random_length(),
					longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX,
					$urandom_range(0, 411775));
			endcase
			if (ph == 7) quiet = 1'b1;
			for (int n = 0; n < 200; n++) begin
				if (ph == 3 && n == 100) begin
					pt.valid <= 1'b0;
					while (pending_dist.size() != 0) @(posedge clk);
				end
				send_random_point();
			end
		end
		pt.valid <= 1'b0;
		drain_pipeline();

		if (pending_dist.size() != 0)
			report_mismatch("points left without a distance", pending_dist.size(), 0);
		if (errors == 0)
			$display("annulus_sector_distance: match");
		else
			$display("annulus_sector_distance: mismatch");
		$finish;
	end

	initial begin
		#20ms;
		$display("annulus_sector_distance: mismatch");
		$finish;
	end

endmodule
